>>> rtl/mdcs_pkg.sv
// Shared types, register map and constants of the motor drive command sequencer.
`timescale 1ns / 1ps

package mdcs_pkg;

    // Field widths
    localparam int DUTY_W   = 8;
    localparam int TICK_W   = 16;
    localparam int ACTION_W = 4;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // Added to the base turn speed to form the default turn duty
    localparam logic [DUTY_W-1:0] TURN_OFFSET = DUTY_W'(30);

    // Register indexes (byte address is four times the index)
    localparam logic [REG_IDX_W-1:0] REG_SPEED_NORMAL   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_TURN     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_CURVE    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TURN_BASE      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION_TICKS = 3'd4;

    // Register reset values
    localparam logic [DUTY_W-1:0] RST_SPEED_NORMAL   = DUTY_W'(200);
    localparam logic [DUTY_W-1:0] RST_SPEED_TURN     = DUTY_W'(150);
    localparam logic [DUTY_W-1:0] RST_SPEED_CURVE    = DUTY_W'(100);
    localparam logic [DUTY_W-1:0] RST_TURN_BASE      = DUTY_W'(80);
    localparam logic [TICK_W-1:0] RST_ROTATION_TICKS = TICK_W'(600);

    // Command codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 4'd0,
        ACT_FWD        = 4'd1,
        ACT_BACK       = 4'd2,
        ACT_ROT_L90    = 4'd3,
        ACT_ROT_R90    = 4'd4,
        ACT_FWD_R      = 4'd5,
        ACT_FWD_L      = 4'd6,
        ACT_BACK_R     = 4'd7,
        ACT_BACK_L     = 4'd8,
        ACT_STOP       = 4'd9,
        ACT_TURN_R     = 4'd10,
        ACT_TURN_L     = 4'd11,
        ACT_TURN_R_DEF = 4'd12,
        ACT_TURN_L_DEF = 4'd13
    } action_t;

    // Input beat
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DUTY_W-1:0]   speed;
    } cmd_t;

    // Output beat
    typedef struct packed {
        logic              standby;
        logic              dir_a;
        logic              dir_b;
        logic [DUTY_W-1:0] pwm_a;
        logic [DUTY_W-1:0] pwm_b;
        logic              rotating;
    } rsp_t;

    // Configuration register values
    typedef struct packed {
        logic [DUTY_W-1:0] speed_normal;
        logic [DUTY_W-1:0] speed_turn;
        logic [DUTY_W-1:0] speed_curve;
        logic [DUTY_W-1:0] turn_base;
        logic [TICK_W-1:0] rotation_ticks;
    } cfg_t;

endpackage

>>> rtl/mdcs_regs.sv
// APB configuration registers of the motor drive command sequencer.
`timescale 1ns / 1ps

module mdcs_regs
    import mdcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write the addressed register; drop writes past the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_normal   <= RST_SPEED_NORMAL;
            cfg_reg.speed_turn     <= RST_SPEED_TURN;
            cfg_reg.speed_curve    <= RST_SPEED_CURVE;
            cfg_reg.turn_base      <= RST_TURN_BASE;
            cfg_reg.rotation_ticks <= RST_ROTATION_TICKS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SPEED_NORMAL:   cfg_reg.speed_normal   <= pwdata[DUTY_W-1:0];
                REG_SPEED_TURN:     cfg_reg.speed_turn     <= pwdata[DUTY_W-1:0];
                REG_SPEED_CURVE:    cfg_reg.speed_curve    <= pwdata[DUTY_W-1:0];
                REG_TURN_BASE:      cfg_reg.turn_base      <= pwdata[DUTY_W-1:0];
                REG_ROTATION_TICKS: cfg_reg.rotation_ticks <= pwdata[TICK_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_SPEED_NORMAL:   prdata = DATA_W'(cfg_reg.speed_normal);
            REG_SPEED_TURN:     prdata = DATA_W'(cfg_reg.speed_turn);
            REG_SPEED_CURVE:    prdata = DATA_W'(cfg_reg.speed_curve);
            REG_TURN_BASE:      prdata = DATA_W'(cfg_reg.turn_base);
            REG_ROTATION_TICKS: prdata = DATA_W'(cfg_reg.rotation_ticks);
            default:            prdata = '0;
        endcase
    end

endmodule

>>> rtl/mdcs_core.sv
// Command decode and drive state of the motor drive command sequencer.
`timescale 1ns / 1ps

module mdcs_core
    import mdcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  cmd_t item,
    input  cfg_t cfg,
    output rsp_t result
);

    logic              rot_reg,    rot_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              en_reg,     en_next;
    logic              dira_reg,   dira_next;
    logic              dirb_reg,   dirb_next;
    logic [DUTY_W-1:0] duty_a_reg, duty_a_next;
    logic [DUTY_W-1:0] duty_b_reg, duty_b_next;

    logic [DUTY_W:0]   turn_sum;
    logic [DUTY_W-1:0] turn_def;
    logic [TICK_W-1:0] elapsed_inc;

    // Default turn duty, saturated
    assign turn_sum = {1'b0, cfg.turn_base} + {1'b0, TURN_OFFSET};
    assign turn_def = turn_sum[DUTY_W] ? {DUTY_W{1'b1}} : turn_sum[DUTY_W-1:0];

    // Saturating millisecond count
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + TICK_W'(1);

    // Decode one command into the next drive state
    always_comb
    begin
        rot_next     = rot_reg;
        elapsed_next = elapsed_reg;
        en_next      = en_reg;
        dira_next    = dira_reg;
        dirb_next    = dirb_reg;
        duty_a_next  = duty_a_reg;
        duty_b_next  = duty_b_reg;
        unique case (action_t'(item.action))
            ACT_TICK:
            begin
                if (rot_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= cfg.rotation_ticks)
                    begin
                        rot_next    = 1'b0;
                        en_next     = 1'b0;
                        duty_a_next = '0;
                        duty_b_next = '0;
                    end
                end
            end
            ACT_FWD, ACT_BACK:
            begin
                rot_next    = 1'b0;
                en_next     = 1'b1;
                dira_next   = (item.action == ACT_FWD);
                dirb_next   = (item.action == ACT_FWD);
                duty_a_next = cfg.speed_normal;
                duty_b_next = cfg.speed_normal;
            end
            ACT_ROT_L90, ACT_ROT_R90:
            begin
                rot_next     = 1'b1;
                elapsed_next = '0;
                en_next      = 1'b1;
                dira_next    = (item.action == ACT_ROT_L90);
                dirb_next    = (item.action == ACT_ROT_R90);
                duty_a_next  = cfg.speed_turn;
                duty_b_next  = cfg.speed_turn;
            end
            ACT_FWD_R, ACT_BACK_R:
            begin
                rot_next    = 1'b0;
                en_next     = 1'b1;
                dira_next   = (item.action == ACT_FWD_R);
                dirb_next   = (item.action == ACT_FWD_R);
                duty_a_next = cfg.speed_curve;
                duty_b_next = cfg.speed_normal;
            end
            ACT_FWD_L, ACT_BACK_L:
            begin
                rot_next    = 1'b0;
                en_next     = 1'b1;
                dira_next   = (item.action == ACT_FWD_L);
                dirb_next   = (item.action == ACT_FWD_L);
                duty_a_next = cfg.speed_normal;
                duty_b_next = cfg.speed_curve;
            end
            ACT_STOP:
            begin
                // Keep direction, rotating flag and count
                en_next     = 1'b0;
                duty_a_next = '0;
                duty_b_next = '0;
            end
            ACT_TURN_R, ACT_TURN_L:
            begin
                rot_next    = 1'b0;
                en_next     = 1'b1;
                dira_next   = (item.action == ACT_TURN_R);
                dirb_next   = (item.action == ACT_TURN_L);
                duty_a_next = item.speed;
                duty_b_next = item.speed;
            end
            ACT_TURN_R_DEF, ACT_TURN_L_DEF:
            begin
                rot_next    = 1'b0;
                en_next     = 1'b1;
                dira_next   = (item.action == ACT_TURN_R_DEF);
                dirb_next   = (item.action == ACT_TURN_L_DEF);
                duty_a_next = turn_def;
                duty_b_next = turn_def;
            end
            default: ;
        endcase
    end

    // Advance the drive state on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg     <= 1'b0;
            elapsed_reg <= '0;
            en_reg      <= 1'b0;
            dira_reg    <= 1'b0;
            dirb_reg    <= 1'b0;
            duty_a_reg  <= '0;
            duty_b_reg  <= '0;
        end
        else if (step)
        begin
            rot_reg     <= rot_next;
            elapsed_reg <= elapsed_next;
            en_reg      <= en_next;
            dira_reg    <= dira_next;
            dirb_reg    <= dirb_next;
            duty_a_reg  <= duty_a_next;
            duty_b_reg  <= duty_b_next;
        end
    end

    // Output lines after this beat is applied
    assign result.standby  = en_next;
    assign result.dir_a    = dira_next;
    assign result.dir_b    = dirb_next;
    assign result.pwm_a    = duty_a_next;
    assign result.pwm_b    = duty_b_next;
    assign result.rotating = rot_next;

endmodule

>>> rtl/motor_drive_command_sequencer_top.sv
// Top level of the motor drive command sequencer: beat registers, state core, registers.
`timescale 1ns / 1ps

// Each cmd beat is a motion command or a one-millisecond tick, and each yields exactly
// one rsp beat holding the driver enable, both direction lines, both PWM duties and
// the rotating flag after the beat is applied. The block takes one beat per cycle while
// the output side is ready; a beat is registered on entry, decoded against the drive
// state combinationally and its result registered. The drive state updates as each
// beat moves into the result register, so back-to-back beats see the effect of those
// before them. Timed 90-degree rotations clear a saturating tick counter and end on
// the tick that brings it to rotation_ticks. Configuration sits on an APB port at byte
// address 4*index and should be written only while no beat is in flight.

module motor_drive_command_sequencer_top
    import mdcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic in_vld_reg;
    cmd_t in_data_reg;
    logic out_vld_reg;
    rsp_t out_data_reg;
    logic advance;
    cfg_t cfg;
    rsp_t core_rsp;

    // Move the held beat on when the result register frees up
    assign advance   = in_vld_reg && (!out_vld_reg || rsp_ready);
    assign cmd_ready = !in_vld_reg || advance;
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_data_reg;

    mdcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mdcs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (core_rsp)
    );

    // Input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            in_vld_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            in_data_reg <= cmd;
        end
    end

    // Result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= core_rsp;
        end
    end

    // A timed rotation always drives the motors in opposite directions
    a_rot_dirs: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.rotating) |-> (rsp.dir_a != rsp.dir_b))
        else $error("rotating result with equal direction lines");

    // Standby means zero duty on both motors
    a_standby_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.standby) |-> (rsp.pwm_a == '0 && rsp.pwm_b == '0))
        else $error("nonzero duty while in standby");

    // A held input beat is never lost while the result side stalls
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_data_reg)))
        else $error("held command beat dropped");

    // Every processed beat lands in the result register
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid)
        else $error("processed beat did not produce a result");

endmodule
